>>> hdl/atl_pkg.sv
// ----------------------------------------------------------------------------
// Assembler token lexer package
// Shared types, constants and character helpers for the lexer block.
// ----------------------------------------------------------------------------
package atl_pkg;

  localparam int LENGTH_BITS = 12;
  localparam int LINE_BITS   = 16;
  localparam int CHAR_BITS   = 8;

  localparam logic [LENGTH_BITS-1:0] LENGTH_MAX = {LENGTH_BITS{1'b1}};
  localparam logic [LINE_BITS-1:0]   LINE_MAX   = {LINE_BITS{1'b1}};

  // Record queue between the lexer front and the output side.
  localparam int QUEUE_DEPTH = 8;
  localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
  localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

  // Output stream packing: value_char, token_length, start_line,
  // start_column and error_code in tdata; kind and flags in tuser.
  localparam int PAYLOAD_BITS = CHAR_BITS + LENGTH_BITS + LINE_BITS + LENGTH_BITS + 2;
  localparam int TDATA_BITS   = ((PAYLOAD_BITS + 7) / 8) * 8;
  localparam int TUSER_BITS   = 5;

  localparam logic [CHAR_BITS-1:0] CH_NUL    = 8'h00;
  localparam logic [CHAR_BITS-1:0] CH_TAB    = 8'h09;
  localparam logic [CHAR_BITS-1:0] CH_LF     = 8'h0A;
  localparam logic [CHAR_BITS-1:0] CH_CR     = 8'h0D;
  localparam logic [CHAR_BITS-1:0] CH_SPACE  = 8'h20;
  localparam logic [CHAR_BITS-1:0] CH_BANG   = 8'h21;
  localparam logic [CHAR_BITS-1:0] CH_QUOTE  = 8'h22;
  localparam logic [CHAR_BITS-1:0] CH_HASH   = 8'h23;
  localparam logic [CHAR_BITS-1:0] CH_MINUS  = 8'h2D;
  localparam logic [CHAR_BITS-1:0] CH_DOT    = 8'h2E;
  localparam logic [CHAR_BITS-1:0] CH_SEMI   = 8'h3B;
  localparam logic [CHAR_BITS-1:0] CH_AT     = 8'h40;
  localparam logic [CHAR_BITS-1:0] CH_BSLASH = 8'h5C;
  localparam logic [CHAR_BITS-1:0] CH_UNDER  = 8'h5F;

  typedef enum logic [3:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_MINUS,
    MODE_NUM,
    MODE_INST,
    MODE_LABEL,
    MODE_REG,
    MODE_STR,
    MODE_ESC,
    MODE_DONE,
    MODE_HALT
  } lex_mode_t;

  typedef enum logic [2:0] {
    KIND_NONE,
    KIND_INT,
    KIND_FLOAT,
    KIND_STRING,
    KIND_LABEL,
    KIND_REGISTER,
    KIND_INSTRUCTION,
    KIND_EOF
  } token_kind_t;

  typedef enum logic [1:0] {
    ERR_UNKNOWN_CHAR,
    ERR_NUMBER_FORMAT,
    ERR_UNTERMINATED
  } error_code_t;

  typedef struct packed {
    token_kind_t             token_kind;
    logic [CHAR_BITS-1:0]    value_char;
    logic                    char_valid;
    logic                    token_end;
    logic [LENGTH_BITS-1:0]  token_length;
    logic [LINE_BITS-1:0]    start_line;
    logic [LENGTH_BITS-1:0]  start_column;
    logic                    error_valid;
    error_code_t             error_code;
  } lex_rec_t;

  // Up to two records produced by one source character, in order.
  typedef struct packed {
    logic [1:0] count;
    lex_rec_t   first;
    lex_rec_t   second;
  } rec_push_t;

  typedef struct packed {
    logic                 hit;
    logic [CHAR_BITS-1:0] code;
  } esc_t;

  function automatic logic is_digit(logic [CHAR_BITS-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(logic [CHAR_BITS-1:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
           (c == CH_UNDER) || is_digit(c);
  endfunction

  // C-style escape letters and the byte each one stands for.
  function automatic esc_t escape_lookup(logic [CHAR_BITS-1:0] c);
    esc_t e;
    e.hit = 1'b1;
    case (c)
      8'h6E:   e.code = 8'h0A; // n
      8'h74:   e.code = 8'h09; // t
      8'h72:   e.code = 8'h0D; // r
      8'h61:   e.code = 8'h07; // a
      8'h62:   e.code = 8'h08; // b
      8'h66:   e.code = 8'h0C; // f
      8'h76:   e.code = 8'h0B; // v
      8'h30:   e.code = 8'h00; // 0
      8'h3F:   e.code = 8'h3F; // ?
      8'h5C:   e.code = 8'h5C; // backslash
      8'h22:   e.code = 8'h22; // double quote
      8'h27:   e.code = 8'h27; // single quote
      default: begin
        e.hit  = 1'b0;
        e.code = 8'h00;
      end
    endcase
    return e;
  endfunction

  // Saturating length add of one or two characters.
  function automatic logic [LENGTH_BITS-1:0] length_add(logic [LENGTH_BITS-1:0] len,
                                                        logic two);
    logic [LENGTH_BITS:0] sum;
    sum = {1'b0, len} + (two ? (LENGTH_BITS+1)'(2) : (LENGTH_BITS+1)'(1));
    return (sum > {1'b0, LENGTH_MAX}) ? LENGTH_MAX : sum[LENGTH_BITS-1:0];
  endfunction

endpackage

>>> hdl/assembler_token_lexer_unit.sv
// ----------------------------------------------------------------------------
// Assembler token lexer unit
// Streams source characters in and token character, token end and error
// records out.
// ----------------------------------------------------------------------------
// One source byte is taken per cycle whenever the record queue has at least
// two free entries, so an uninterrupted stream runs at one byte per clock.
// Each byte yields zero, one or two records; the output side delivers one
// record per clock while the sink is ready. Input ready drops when the
// eight-entry queue holds more than six records, which happens only when
// records arrive faster than the sink takes them: when the sink stalls, or
// when bytes that yield two records (a token end and the next token's first
// record, a minus and its digit, or an unknown escape) come back to back.
// A byte's records reach the output behind older ones. After an error or the
// end-of-file token the block takes bytes but gives no records until reset.
module assembler_token_lexer_unit (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [7:0]                       s_axis_tdata,  // character
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // value_char, token_length, start_line, start_column, error_code, zero pad
  output logic [atl_pkg::TDATA_BITS-1:0]   m_axis_tdata,
  // token_kind, char_valid, error_valid
  output logic [atl_pkg::TUSER_BITS-1:0]   m_axis_tuser,
  output logic                             m_axis_tlast   // token_end
);
  import atl_pkg::*;

  rec_push_t push;
  lex_rec_t  out_rec;
  logic      room;
  logic      accept;

  assign s_axis_tready = room;
  assign accept        = s_axis_tvalid && room;

  atl_front u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .character (s_axis_tdata),
    .push      (push)
  );

  atl_back u_back (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_rec   (out_rec),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready)
  );

  assign m_axis_tdata = TDATA_BITS'({out_rec.error_code, out_rec.start_column,
                                     out_rec.start_line, out_rec.token_length,
                                     out_rec.value_char});
  assign m_axis_tuser = {out_rec.error_valid, out_rec.char_valid, out_rec.token_kind};
  assign m_axis_tlast = out_rec.token_end;

`ifndef ASSERT_OFF
  // Records enter the queue only for an accepted input item.
  a_push_needs_accept: assert property (@(posedge clk) disable iff (rst)
    (push.count != 2'd0) |-> (s_axis_tvalid && s_axis_tready))
    else $error("records pushed without an accepted item");

  // An error record carries no token kind, character or end mark.
  a_error_record_clean: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && out_rec.error_valid) |->
      (out_rec.token_kind == KIND_NONE && !out_rec.token_end && !out_rec.char_valid))
    else $error("error record mixed with token fields");

  // A token end record never doubles as a character record.
  a_end_not_char: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tlast) |->
      (!out_rec.char_valid && out_rec.token_kind != KIND_NONE))
    else $error("token end record malformed");
`endif

endmodule

>>> hdl/atl_front.sv
// ----------------------------------------------------------------------------
// Assembler token lexer front
// Classifies each accepted character, tracks the lexer mode and source
// position, and produces up to two records per character.
// ----------------------------------------------------------------------------
module atl_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           accept,
  input  logic [atl_pkg::CHAR_BITS-1:0]  character,
  output atl_pkg::rec_push_t             push
);
  import atl_pkg::*;

  lex_mode_t              mode, mode_next;
  logic                   dot_seen, dot_seen_next;
  logic [LENGTH_BITS-1:0] length_count, length_count_next;
  logic [LINE_BITS-1:0]   line_count, line_count_next;
  logic [LENGTH_BITS-1:0] column_count, column_count_next;
  logic [LINE_BITS-1:0]   token_line, token_line_next;
  logic [LENGTH_BITS-1:0] token_column, token_column_next;

  function automatic lex_rec_t mk_char(logic [CHAR_BITS-1:0] ch, logic [LINE_BITS-1:0] ln,
                                       logic [LENGTH_BITS-1:0] col);
    lex_rec_t r;
    r            = '0;
    r.value_char = ch;
    r.char_valid = 1'b1;
    r.start_line = ln;
    r.start_column = col;
    return r;
  endfunction

  function automatic lex_rec_t mk_end(token_kind_t kind, logic [LENGTH_BITS-1:0] len,
                                      logic [LINE_BITS-1:0] ln,
                                      logic [LENGTH_BITS-1:0] col);
    lex_rec_t r;
    r              = '0;
    r.token_kind   = kind;
    r.token_end    = 1'b1;
    r.token_length = len;
    r.start_line   = ln;
    r.start_column = col;
    return r;
  endfunction

  function automatic lex_rec_t mk_err(error_code_t code, logic [LINE_BITS-1:0] ln,
                                      logic [LENGTH_BITS-1:0] col);
    lex_rec_t r;
    r              = '0;
    r.error_valid  = 1'b1;
    r.error_code   = code;
    r.start_line   = ln;
    r.start_column = col;
    return r;
  endfunction

  lex_rec_t r0, r1, srec;
  logic     v0, v1, svalid, do_start;
  esc_t     esc;

  assign esc = escape_lookup(character);

  always_comb begin
    mode_next         = mode;
    dot_seen_next     = dot_seen;
    length_count_next = length_count;
    line_count_next   = line_count;
    column_count_next = column_count;
    token_line_next   = token_line;
    token_column_next = token_column;
    r0       = '0;
    r1       = '0;
    v0       = 1'b0;
    v1       = 1'b0;
    srec     = '0;
    svalid   = 1'b0;
    do_start = 1'b0;

    unique case (mode)
      MODE_COMMENT: begin
        if (character == CH_NUL) begin
          do_start = 1'b1;
        end else if (character == CH_LF) begin
          mode_next = MODE_IDLE;
        end
      end
      MODE_MINUS: begin
        if (is_digit(character)) begin
          r0 = mk_char(CH_MINUS, token_line, token_column);
          r1 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          v1 = 1'b1;
          length_count_next = length_add(length_count, 1'b1);
          mode_next = MODE_NUM;
        end else begin
          r0 = mk_err(ERR_NUMBER_FORMAT, token_line, token_column);
          v0 = 1'b1;
          mode_next = MODE_HALT;
        end
      end
      MODE_NUM: begin
        if (is_digit(character) || (character == CH_DOT && !dot_seen)) begin
          if (character == CH_DOT) begin
            dot_seen_next = 1'b1;
          end
          r0 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          length_count_next = length_add(length_count, 1'b0);
        end else begin
          r0 = mk_end(dot_seen ? KIND_FLOAT : KIND_INT, length_count, token_line,
                      token_column);
          v0 = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_INST, MODE_LABEL: begin
        if (is_ident(character)) begin
          r0 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          length_count_next = length_add(length_count, 1'b0);
        end else begin
          r0 = mk_end((mode == MODE_INST) ? KIND_INSTRUCTION : KIND_LABEL, length_count,
                      token_line, token_column);
          v0 = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_REG: begin
        if (is_digit(character)) begin
          r0 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          length_count_next = length_add(length_count, 1'b0);
        end else begin
          r0 = mk_end(KIND_REGISTER, length_count, token_line, token_column);
          v0 = 1'b1;
          do_start = 1'b1;
        end
      end
      MODE_STR: begin
        if (character == CH_QUOTE) begin
          r0 = mk_end(KIND_STRING, length_count, token_line, token_column);
          v0 = 1'b1;
          mode_next = MODE_IDLE;
        end else if (character == CH_NUL) begin
          r0 = mk_err(ERR_UNTERMINATED, token_line, token_column);
          v0 = 1'b1;
          mode_next = MODE_HALT;
        end else if (character == CH_BSLASH) begin
          mode_next = MODE_ESC;
        end else begin
          r0 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          length_count_next = length_add(length_count, 1'b0);
        end
      end
      MODE_ESC: begin
        if (character == CH_NUL) begin
          r0 = mk_err(ERR_UNTERMINATED, token_line, token_column);
          v0 = 1'b1;
          mode_next = MODE_HALT;
        end else if (esc.hit) begin
          r0 = mk_char(esc.code, token_line, token_column);
          v0 = 1'b1;
          length_count_next = length_add(length_count, 1'b0);
          mode_next = MODE_STR;
        end else begin
          // An unknown escape keeps its backslash.
          r0 = mk_char(CH_BSLASH, token_line, token_column);
          r1 = mk_char(character, token_line, token_column);
          v0 = 1'b1;
          v1 = 1'b1;
          length_count_next = length_add(length_count, 1'b1);
          mode_next = MODE_STR;
        end
      end
      MODE_DONE, MODE_HALT: begin
        mode_next = mode;
      end
      default: begin
        do_start = 1'b1;
      end
    endcase

    // A terminating character is taken again as the start of what follows.
    if (do_start) begin
      token_line_next   = line_count;
      token_column_next = column_count;
      length_count_next = '0;
      dot_seen_next     = 1'b0;
      unique case (character) inside
        CH_NUL: begin
          srec      = mk_end(KIND_EOF, '0, line_count, column_count);
          svalid    = 1'b1;
          mode_next = MODE_DONE;
        end
        CH_SPACE, CH_LF, CH_CR, CH_TAB: mode_next = MODE_IDLE;
        CH_SEMI:  mode_next = MODE_COMMENT;
        CH_MINUS: mode_next = MODE_MINUS;
        CH_BANG:  mode_next = MODE_INST;
        CH_HASH:  mode_next = MODE_LABEL;
        CH_AT:    mode_next = MODE_REG;
        CH_QUOTE: mode_next = MODE_STR;
        default: begin
          if (is_digit(character)) begin
            srec              = mk_char(character, line_count, column_count);
            svalid            = 1'b1;
            length_count_next = LENGTH_BITS'(1);
            mode_next         = MODE_NUM;
          end else begin
            srec      = mk_err(ERR_UNKNOWN_CHAR, line_count, column_count);
            svalid    = 1'b1;
            mode_next = MODE_HALT;
          end
        end
      endcase
      if (v0) begin
        r1 = srec;
        v1 = svalid;
      end else begin
        r0 = srec;
        v0 = svalid;
      end
    end

    if (mode != MODE_DONE && mode != MODE_HALT && character != CH_NUL) begin
      if (character == CH_LF) begin
        line_count_next   = (line_count == LINE_MAX) ? line_count : line_count + 1'b1;
        column_count_next = LENGTH_BITS'(1);
      end else if (column_count != LENGTH_MAX) begin
        column_count_next = column_count + 1'b1;
      end
    end
  end

  always_comb begin
    push.first  = r0;
    push.second = r1;
    push.count  = accept ? {v1, v0 & ~v1} : 2'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= MODE_IDLE;
      dot_seen     <= 1'b0;
      length_count <= '0;
      line_count   <= LINE_BITS'(1);
      column_count <= LENGTH_BITS'(1);
      token_line   <= LINE_BITS'(1);
      token_column <= LENGTH_BITS'(1);
    end else if (accept) begin
      mode         <= mode_next;
      dot_seen     <= dot_seen_next;
      length_count <= length_count_next;
      line_count   <= line_count_next;
      column_count <= column_count_next;
      token_line   <= token_line_next;
      token_column <= token_column_next;
    end
  end

endmodule

>>> hdl/atl_back.sv
// ----------------------------------------------------------------------------
// Assembler token lexer back end
// Record queue that takes up to two records a cycle from the front and
// hands one record a cycle to the output stream while it is ready.
// ----------------------------------------------------------------------------
module atl_back (
  input  logic                clk,
  input  logic                rst,
  input  atl_pkg::rec_push_t  push,
  output logic                room,
  output atl_pkg::lex_rec_t   out_rec,
  output logic                out_valid,
  input  logic                out_ready
);
  import atl_pkg::*;

  lex_rec_t             mem [QUEUE_DEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QCNT_BITS-1:0] count, count_next;
  logic                 pop;

  assign out_valid  = (count != '0);
  assign pop        = out_valid && out_ready;
  assign out_rec    = mem[rd_ptr];
  // Room is judged on the registered fill so ready never waits on the sink.
  assign room       = (count <= QCNT_BITS'(QUEUE_DEPTH - 2));
  assign count_next = count + QCNT_BITS'(push.count) - QCNT_BITS'(pop);

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr + QPTR_BITS'(1)] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_BITS'(push.count);
      rd_ptr <= rd_ptr + QPTR_BITS'(pop);
      count  <= count_next;
    end
  end

endmodule
